// ===== rtl/apsp_pkg.sv =====
// Shared constants, item types and control structs for the all-pairs shortest path block.
`default_nettype none

package apsp_pkg;

   // graph size
   localparam int MAX_VERTICES = 16;
   localparam int VIDX_W       = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

   // item field widths
   localparam int ROW_W        = 16;
   localparam int IDX_FIELD_W  = 4;
   localparam int CFG_W        = 5;
   localparam int OUT_DIST_W   = 4;

   // stored hop count: enough for MAX_VERTICES-1 hops plus the unreachable mark
   localparam int DIST_W       = $clog2(MAX_VERTICES) + 1;
   localparam logic [DIST_W-1:0] DIST_UNREACH = '1;
   localparam logic [DIST_W-1:0] DIST_ZERO    = '0;
   localparam logic [DIST_W-1:0] DIST_ONE     = DIST_W'(1);
   localparam logic [DIST_W-1:0] DIST_OUT_MAX = DIST_W'((1 << OUT_DIST_W) - 1);

   localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(MAX_VERTICES);
   localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_VERTICES);

   // request codes
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef logic [DIST_W-1:0] dist_type;
   typedef dist_type [MAX_VERTICES-1:0] dist_row_type;

   typedef struct packed {
      logic                   req_type;
      logic [IDX_FIELD_W-1:0] row_index;
      logic [ROW_W-1:0]       row_bits;
      logic                   last_row;
      logic [IDX_FIELD_W-1:0] target_vertex;
   } req_item_type;

   typedef struct packed {
      logic [OUT_DIST_W-1:0] distance;
      logic                  reachable;
   } rsp_item_type;

   // distance memory command from the closure engine
   typedef struct packed {
      logic                    rd_en;
      logic [VIDX_W-1:0]       rd_addr;
      logic                    wr_en;
      logic [VIDX_W-1:0]       wr_addr;
      logic [MAX_VERTICES-1:0] wr_mask;   // per column write enable
      dist_row_type            wr_data;
   } mem_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/apsp_channels.sv =====
// Valid/ready channel interfaces for request and response items.
`default_nettype none

interface apsp_req_if import apsp_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface apsp_rsp_if import apsp_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/apsp_lane.sv =====
// One column lane: initial distance from an edge bit, or one min-plus relaxation.
`default_nettype none

module apsp_lane import apsp_pkg::*; (
   input  logic     init_mode,
   input  logic     edge_bit,
   input  logic     diag,
   input  dist_type cur,
   input  dist_type dik,
   input  dist_type dkj,
   output dist_type nxt
);

   logic [DIST_W:0] sum_wide;
   dist_type        sum_sat;

   always_comb begin
      sum_wide = {1'b0, dik} + {1'b0, dkj};
      if (dik == DIST_UNREACH || dkj == DIST_UNREACH ||
          sum_wide >= {1'b0, DIST_UNREACH}) begin
         sum_sat = DIST_UNREACH;
      end else begin
         sum_sat = sum_wide[DIST_W-1:0];
      end

      if (init_mode) begin
         if (diag) begin
            nxt = DIST_ZERO;
         end else if (edge_bit) begin
            nxt = DIST_ONE;
         end else begin
            nxt = DIST_UNREACH;
         end
      end else begin
         nxt = (sum_sat < cur) ? sum_sat : cur;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/apsp_engine.sv =====
// Closure sequencer: row init, pivot load, and one row per cycle across all lanes.
`default_nettype none

module apsp_engine import apsp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CNT_W-1:0]  cnt,
   input  logic [ROW_W-1:0]  adj_row,
   input  dist_row_type      rd_data,
   output logic [VIDX_W-1:0] adj_addr,
   output mem_cmd_type       mem_cmd,
   output logic              busy
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INIT   = 3'd1;
   localparam logic [2:0] ST_PIV_RD = 3'd2;
   localparam logic [2:0] ST_PIV_LD = 3'd3;
   localparam logic [2:0] ST_ROWS   = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [VIDX_W-1:0]       i_ff, i_in;
   logic [VIDX_W-1:0]       k_ff, k_in;
   dist_row_type            pivot_ff, pivot_in;
   dist_row_type            lane_out;
   logic [MAX_VERTICES-1:0] lane_en;
   logic [VIDX_W-1:0]       last_idx;
   logic                    i_last;
   logic                    k_last;
   dist_type                dik;

   assign last_idx = VIDX_W'(cnt - CNT_W'(1));
   assign i_last   = (i_ff == last_idx);
   assign k_last   = (k_ff == last_idx);
   assign dik      = rd_data[k_ff];

   // lanes: column j of the current row
   for (genvar j = 0; j < MAX_VERTICES; j++) begin : g_lane
      logic edge_j;
      if (j < ROW_W) begin : g_edge
         assign edge_j = adj_row[j];
      end else begin : g_noedge
         assign edge_j = 1'b0;
      end
      // only columns inside the vertex count are written
      assign lane_en[j] = (CNT_W'(j) < cnt);
      apsp_lane u_lane (
         .init_mode (state_ff == ST_INIT),
         .edge_bit  (edge_j),
         .diag      (i_ff == VIDX_W'(j)),
         .cur       (rd_data[j]),
         .dik       (dik),
         .dkj       (pivot_ff[j]),
         .nxt       (lane_out[j])
      );
   end

   always_comb begin
      state_in        = state_ff;
      i_in            = i_ff;
      k_in            = k_ff;
      pivot_in        = pivot_ff;
      mem_cmd         = '0;
      mem_cmd.wr_addr = i_ff;
      mem_cmd.wr_mask = lane_en;
      mem_cmd.wr_data = lane_out;   // merge: lanes packed into one row write
      adj_addr        = i_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               i_in     = '0;
               k_in     = '0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            mem_cmd.wr_en = 1'b1;
            if (i_last) begin
               i_in     = '0;
               state_in = ST_PIV_RD;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_PIV_RD: begin
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = k_ff;
            state_in        = ST_PIV_LD;
         end
         ST_PIV_LD: begin
            pivot_in        = rd_data;
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = '0;
            i_in            = '0;
            state_in        = ST_ROWS;
         end
         ST_ROWS: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = i_ff + 1'b1;
            if (i_last) begin
               if (k_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_PIV_RD;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      pivot_ff <= pivot_in;
   end

endmodule

`default_nettype wire

// ===== rtl/all_pairs_shortest_path.sv =====
// Top level: request intake, adjacency rows, distance memory, closure engine, response register.
`default_nettype none

// Unweighted all-pairs shortest path by Floyd-Warshall over up to 16 vertices.
// A load item writes one adjacency row (bit j = edge to vertex j) and a read item
// returns the hop distance between row_index and target_vertex, with reachable low
// (and distance 0) when no path exists or either vertex is at or beyond the
// configured vertex_count. A load marked last_row starts the closure once its row
// is stored; the request channel is held off while it runs. Loads and reads are
// taken one per cycle when the response side drains; a read answers through the
// registered distance memory read and then the response register. The closure
// first seeds the distances row by row, then per pivot reads the pivot row,
// latches it, and relaxes the rows in use one after another, all 16 column lanes
// relaxing a row together against the pivot row. The single read port of the
// distance memory sets the pace of the closure. Rows and columns at or beyond
// vertex_count keep what an earlier closure left. Writing vertex_count 0 disables
// the closure; values above 16 act as 16. Reads before any closure, or closures
// over rows never loaded, give undefined data.

module all_pairs_shortest_path import apsp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   apsp_req_if.sink         req_chan,
   apsp_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   // config
   logic [CFG_W-1:0] vcount_ff;
   logic [CNT_W-1:0] act_cnt;

   // intake
   logic req_acc;
   logic ld_acc;
   logic rd_acc;
   logic start;

   // adjacency rows, no reset (written before use)
   logic [ROW_W-1:0]  adj_ff [MAX_VERTICES];
   logic [VIDX_W-1:0] adj_addr;

   // distance memory: one row of all columns per entry
   dist_row_type      dist_mem [MAX_VERTICES];
   dist_row_type      rd_data_ff;
   mem_cmd_type       eng_cmd;
   logic              eng_busy;
   logic              mem_rd_en;
   logic [VIDX_W-1:0] mem_rd_addr;

   // read pending between memory access and response register
   logic                   pend_ff, pend_in;
   logic                   pend_move;
   logic [IDX_FIELD_W-1:0] tgt_ff;
   logic                   inrange_ff;
   dist_type               pend_dist;
   rsp_item_type           rsp_calc;

   // response register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff;

   // vertex count clamps at MAX_VERTICES
   assign act_cnt = (vcount_ff > CFG_W'(MAX_VERTICES)) ? CNT_MAX : CNT_W'(vcount_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         vcount_ff <= csr_wr_data;
      end
   end

   // pending read leaves when the response slot is free or being emptied
   assign pend_move      = pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !eng_busy && (!pend_ff || pend_move);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign ld_acc         = req_acc && (req_chan.payload.req_type == REQ_LOAD);
   assign rd_acc         = req_acc && (req_chan.payload.req_type == REQ_READ);
   assign start          = ld_acc && req_chan.payload.last_row && (act_cnt != '0);

   always_ff @(posedge clock) begin
      if (ld_acc) begin
         adj_ff[req_chan.payload.row_index] <= req_chan.payload.row_bits;
      end
   end

   apsp_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .cnt      (act_cnt),
      .adj_row  (adj_ff[adj_addr]),
      .rd_data  (rd_data_ff),
      .adj_addr (adj_addr),
      .mem_cmd  (eng_cmd),
      .busy     (eng_busy)
   );

   // read port shared: engine while busy, read items otherwise
   assign mem_rd_en   = eng_cmd.rd_en || rd_acc;
   assign mem_rd_addr = eng_busy ? eng_cmd.rd_addr : req_chan.payload.row_index;

   always_ff @(posedge clock) begin
      if (eng_cmd.wr_en) begin
         for (int j = 0; j < MAX_VERTICES; j++) begin
            if (eng_cmd.wr_mask[j]) begin
               dist_mem[eng_cmd.wr_addr][j] <= eng_cmd.wr_data[j];
            end
         end
      end
      if (mem_rd_en) begin
         rd_data_ff <= dist_mem[mem_rd_addr];
      end
   end

   // read item bookkeeping
   assign pend_in = rd_acc || (pend_ff && !pend_move);

   always_ff @(posedge clock) begin
      if (rd_acc) begin
         tgt_ff     <= req_chan.payload.target_vertex;
         inrange_ff <= (CNT_W'(req_chan.payload.row_index) < act_cnt) &&
                       (CNT_W'(req_chan.payload.target_vertex) < act_cnt);
      end
   end

   // column select and output formatting
   assign pend_dist = rd_data_ff[tgt_ff];

   always_comb begin
      if (!inrange_ff || pend_dist == DIST_UNREACH) begin
         rsp_calc.distance  = '0;
         rsp_calc.reachable = 1'b0;
      end else begin
         rsp_calc.reachable = 1'b1;
         if (pend_dist > DIST_OUT_MAX) begin
            rsp_calc.distance = '1;
         end else begin
            rsp_calc.distance = pend_dist[OUT_DIST_W-1:0];
         end
      end
   end

   assign rsp_valid_in = pend_move || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_data_ff <= rsp_calc;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // no intake while the closure owns the memory
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      eng_busy |-> !req_chan.ready)
      else $error("request accepted during closure");

   // a closing load hands the block to the engine on the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> eng_busy)
      else $error("closure did not start");

   // distance memory written only by a running closure
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      eng_cmd.wr_en |-> eng_busy)
      else $error("distance write outside closure");

   // a pending read with a free response slot shows up next cycle
   a_pend_moves: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("pending read lost");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the all-pairs shortest path block: random graphs, reads, pacing.

module tb;
   import apsp_pkg::*;

   // run limits, in clock cycles
   localparam int CYCLE_LIMIT  = 2000000;
   // leave margin for a closure at 16 vertices before touching the register
   localparam int SETTLE_WAIT  = 400;
   // long receiver hold-off, long enough to fill the block and back up intake
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 80;
   // predictor's own unreachable mark, wider than any real hop count
   localparam logic [7:0] HOP_NONE = 8'hFF;

   typedef enum logic [1:0] {
      PACE_FULL,
      PACE_SEND_GAPS,
      PACE_RECV_STALLS,
      PACE_BOTH
   } pace_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   apsp_req_if req_bus ();
   apsp_rsp_if rsp_bus ();

   all_pairs_shortest_path DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Shared testbench state
   // ---------------------------------------------------------------------
   req_item_type pending_reqs[$];   // items waiting to be offered, in order
   rsp_item_type hops_due[$];       // expected answers, oldest first
   pace_type     pace;
   int           mismatches;
   int           queued;            // items queued so far, for phase sizing
   logic         req_fired;         // request item accepted at the last rising edge
   logic         stall_order;       // raised once by the sequencer for the long hold-off
   logic         stall_taken;
   int           stall_left;

   // predictor state: adjacency rows, hop table, vertex count
   logic [ROW_W-1:0] adj_rows [MAX_VERTICES];
   logic [7:0]       hop_table [MAX_VERTICES][MAX_VERTICES];
   logic [CFG_W-1:0] live_vertices;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // vertices in use; anything above the store size acts as the full store
   function automatic int unsigned span(input logic [CFG_W-1:0] v);
      return (v > MAX_VERTICES) ? MAX_VERTICES : int'(v);
   endfunction

   // Floyd-Warshall over the vertices in use; sums saturate at unreachable
   function automatic void settle_hops();
      int unsigned n;
      logic [8:0]  s;
      n = span(live_vertices);
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            hop_table[i][j] = adj_rows[i][j] ? 8'd1 : HOP_NONE;
            if (i == j) hop_table[i][j] = 8'd0;
         end
      end
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               s = {1'b0, hop_table[i][k]} + {1'b0, hop_table[k][j]};
               if (s > HOP_NONE) s = {1'b0, HOP_NONE};
               if (s[7:0] < hop_table[i][j]) hop_table[i][j] = s[7:0];
            end
         end
      end
   endfunction

   // apply one accepted item; a read leaves one expected answer
   function automatic void take_request(input req_item_type it);
      int unsigned  n;
      logic [7:0]   d;
      rsp_item_type ans;
      if (it.req_type == REQ_LOAD) begin
         adj_rows[it.row_index] = it.row_bits;
         if (it.last_row) settle_hops();
      end else begin
         n = span(live_vertices);
         ans = '0;
         // pairs outside the vertices in use read as unreachable
         if (it.row_index < n && it.target_vertex < n) begin
            d = hop_table[it.row_index][it.target_vertex];
            if (d != HOP_NONE) begin
               ans.distance  = (d > 8'd15) ? 4'd15 : d[3:0];
               ans.reachable = 1'b1;
            end
         end
         hops_due.insert(hops_due.size(), ans);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Clock, pacing helpers
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic sender_gap();
      case (pace)
         PACE_SEND_GAPS: return $urandom_range(0, 99) < 67;
         PACE_BOTH:      return $urandom_range(0, 99) < 6;
         default:        return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_gap();
      case (pace)
         PACE_RECV_STALLS: return $urandom_range(0, 99) < 67;
         PACE_BOTH:        return $urandom_range(0, 99) < 6;
         default:          return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offers queued items at the falling edge, holds valid until taken
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fired) begin
         if (pending_reqs.size() > 0 && !sender_gap()) begin
            req_bus.payload <= pending_reqs.pop_front();
            req_bus.valid   <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here
   always @(negedge clock) begin
      if (stall_order && !stall_taken) begin
         stall_taken   <= 1'b1;
         stall_left    <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !receiver_gap();
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predicts on each accepted request, checks each accepted answer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      req_fired <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) take_request(req_bus.payload);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (hops_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected answer: expected none, actual distance %0d reachable %0b",
                     $time, rsp_bus.payload.distance, rsp_bus.payload.reachable);
         end else begin
            if (rsp_bus.payload.distance !== hops_due[0].distance) begin
               mismatches++;
               $display("%0t: distance mismatch: expected %0d, actual %0d",
                        $time, hops_due[0].distance, rsp_bus.payload.distance);
            end
            if (rsp_bus.payload.reachable !== hops_due[0].reachable) begin
               mismatches++;
               $display("%0t: reachable mismatch: expected %0b, actual %0b",
                        $time, hops_due[0].reachable, rsp_bus.payload.reachable);
            end
            void'(hops_due.pop_front());
         end
      end
   end

   // Watchdog: a hung block ends the run here
   initial begin : watchdog
      for (int cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------
   task automatic queue_load(input int unsigned row, input logic [ROW_W-1:0] bits,
                             input logic last);
      req_item_type it;
      it.req_type      = REQ_LOAD;
      it.row_index     = row[IDX_FIELD_W-1:0];
      it.row_bits      = bits;
      it.last_row      = last;
      it.target_vertex = IDX_FIELD_W'($urandom_range(0, 15));   // ignored on loads
      pending_reqs.insert(pending_reqs.size(), it);
      queued++;
   endtask

   task automatic queue_read(input int unsigned src, input int unsigned dst);
      req_item_type it;
      it.req_type      = REQ_READ;
      it.row_index     = src[IDX_FIELD_W-1:0];
      it.target_vertex = dst[IDX_FIELD_W-1:0];
      it.row_bits      = ROW_W'($urandom);                      // ignored on reads
      it.last_row      = 1'($urandom_range(0, 1));
      pending_reqs.insert(pending_reqs.size(), it);
      queued++;
   endtask

   // vertex index, mostly inside the vertices in use
   function automatic int unsigned pick_vertex(input int unsigned n);
      if (n > 0 && $urandom_range(0, 9) != 0) return $urandom_range(0, n - 1);
      return $urandom_range(0, 15);
   endfunction

   // one well-formed graph: some rows, the last one marked to start the closure, then reads
   task automatic queue_graph(input int unsigned n);
      int unsigned rows;
      int unsigned style;
      int unsigned r;
      int unsigned reads;
      logic [ROW_W-1:0] bits;
      rows  = $urandom_range(1, (n > 0) ? n : 4);
      style = $urandom_range(0, 3);
      for (int i = 0; i < rows; i++) begin
         r = pick_vertex(n);
         case (style)
            0:       bits = ROW_W'($urandom & $urandom & $urandom);   // sparse
            1:       bits = ROW_W'($urandom & $urandom);
            2:       bits = ROW_W'($urandom);                         // dense
            default: bits = 16'(1) << ((r + 1) % 16);                 // chains, long paths
         endcase
         queue_load(r, bits, i == rows - 1);
      end
      reads = $urandom_range(3, 12);
      for (int i = 0; i < reads; i++) queue_read(pick_vertex(n), pick_vertex(n));
   endtask

   // fully random item
   task automatic queue_noise();
      req_item_type it;
      it.req_type      = 1'($urandom_range(0, 1));
      it.row_index     = IDX_FIELD_W'($urandom_range(0, 15));
      it.row_bits      = ROW_W'($urandom);
      it.last_row      = 1'($urandom_range(0, 1));
      it.target_vertex = IDX_FIELD_W'($urandom_range(0, 15));
      pending_reqs.insert(pending_reqs.size(), it);
      queued++;
   endtask

   // sender holds off until every item is taken and every answer is in,
   // then lets a closure that produced no answer finish
   task automatic drain();
      while (pending_reqs.size() > 0 || req_bus.valid || hops_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [CFG_W-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      live_vertices = v;
   endtask

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   localparam int NUM_PHASES = 9;
   logic [CFG_W-1:0] phase_count [NUM_PHASES] = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd7,
                                                  5'd3, 5'd12, 5'd16, 5'd5};
   pace_type         phase_pace  [NUM_PHASES] = '{PACE_SEND_GAPS, PACE_RECV_STALLS,
                                                  PACE_BOTH, PACE_FULL, PACE_SEND_GAPS,
                                                  PACE_RECV_STALLS, PACE_BOTH, PACE_FULL,
                                                  PACE_FULL};

   initial begin : sequencer
      int unsigned n;
      int          phase_start;

      // known values on every input from time zero
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      req_fired       = 1'b0;
      stall_order     = 1'b0;
      stall_taken     = 1'b0;
      stall_left      = 0;
      mismatches      = 0;
      queued          = 0;
      pace            = PACE_FULL;
      live_vertices   = CFG_RESET;
      foreach (adj_rows[i]) adj_rows[i] = '0;
      foreach (hop_table[i, j]) hop_table[i][j] = '0;

      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset vertex count. All 16 rows are loaded and
      // closed first, so no later read or closure touches an unwritten entry.
      // Chain 0->1->...->15 gives the longest path; row 15 self loop.
      for (int r = 0; r < 16; r++)
         queue_load(r, (r < 15) ? (16'(1) << (r + 1)) : 16'h8000, r == 15);
      queue_read(0, 15);   // fifteen hops
      queue_read(15, 0);   // unreachable
      queue_read(3, 3);    // diagonal
      queue_read(0, 1);
      queue_load(15, 16'hFFFF, 1'b1);   // full row closes the cycle
      queue_read(15, 0);
      queue_read(14, 0);
      queue_read(2, 9);
      queue_load(4, 16'h0000, 1'b0);    // empty row, no closure yet
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         pace = phase_pace[p];
         write_vertex_count(phase_count[p]);
         n = span(phase_count[p]);
         phase_start = queued;
         if (p == 3) begin
            // long receiver hold-off while reads keep coming
            stall_order = 1'b1;
            for (int i = 0; i < 30; i++) queue_read(pick_vertex(n), pick_vertex(n));
         end
         while (queued - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) != 0) queue_graph(n);
            else queue_noise();
         end
         drain();
      end

      if (hops_due.size() != 0) begin
         mismatches++;
         $display("%0t: %0d answers never arrived, expected distance %0d reachable %0b",
                  $time, hops_due.size(), hops_due[0].distance, hops_due[0].reachable);
      end
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/apsp_pkg.sv
rtl/apsp_channels.sv
rtl/apsp_lane.sv
rtl/apsp_engine.sv
rtl/all_pairs_shortest_path.sv
bench/tb.sv
